// ===== hw/rtl/cch_pkg.sv =====
`default_nettype none
package cch_pkg;

   // Symbol alphabet, digit 0 in the top byte
   localparam logic [91*8-1:0] SYM_CHARS =
      "qwertyuiopasdfghjklzxcvbnmQWERTYUIOPASDFGHJKLZXCVBNM1234567890!@#$^&*()-=_+|[]{};':,.<>/?`~";

   localparam logic [31:0] HASH_MULT = 32'h9E3779B9;

   localparam logic CSR_CODE_WIDTH      = 1'b0;
   localparam logic CSR_TRANSPARENT_KEY = 1'b1;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic [9:0] quot;
      logic [6:0] rem;
   } div91_type;

   // v / 91 by reciprocal 720/65536; estimate is low by at most one
   function automatic div91_type div91(input logic [15:0] v);
      logic [25:0] prod;
      logic [9:0]  q;
      logic [16:0] r;
      div91_type   res;
      prod = 26'(v) * 26'd720;
      q    = prod[25:16];
      r    = 17'(v) - 17'(q) * 17'd91;
      if (r >= 17'd91) begin
         q = q + 10'd1;
         r = r - 17'd91;
      end
      res.quot = q;
      res.rem  = r[6:0];
      return res;
   endfunction

   function automatic logic [6:0] sym_char(input logic [6:0] d);
      return SYM_CHARS[8*(90 - int'(d)) +: 7];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cch_front.sv =====
`default_nettype none
module cch_front
   import cch_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int HW          = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          req_func,
   input  wire logic [31:0]   req_color_rgba,
   input  wire logic          hold,
   output logic               q_valid,
   output logic               q_func,
   output logic [31:0]        q_color,
   output logic [HW-1:0]      q_home,
   input  wire logic          q_pop
);

   localparam int DW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = 32 + DW;

   logic           s1_valid_ff, s1_valid_in;
   logic           s1_func_ff;
   logic [31:0]    s1_color_ff;
   logic [31:0]    s1_frac_ff;
   logic [31:0]    frac;
   logic [PW-1:0]  home_prod;
   logic           accept, push, q_full;

   logic           ent_func_ff  [2];
   logic [31:0]    ent_color_ff [2];
   logic [HW-1:0]  ent_home_ff  [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff, count_in;

   assign q_full      = (count_ff == 2'd2);
   assign req_stall   = hold | (s1_valid_ff & q_full);
   assign accept      = req_valid & ~req_stall;
   assign push        = s1_valid_ff & ~q_full;
   assign s1_valid_in = accept | (s1_valid_ff & q_full);
   assign frac        = req_color_rgba * HASH_MULT;
   assign home_prod   = PW'(s1_frac_ff) * PW'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_func_ff  <= req_func;
         s1_color_ff <= req_color_rgba;
         s1_frac_ff  <= frac;
      end
   end

   always_comb begin
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (push) begin
         ent_func_ff[wr_ptr_ff]  <= s1_func_ff;
         ent_color_ff[wr_ptr_ff] <= s1_color_ff;
         ent_home_ff[wr_ptr_ff]  <= home_prod[32 +: HW];
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_func  = ent_func_ff[rd_ptr_ff];
   assign q_color = ent_color_ff[rd_ptr_ff];
   assign q_home  = ent_home_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ===== hw/rtl/cch_back.sv =====
`default_nettype none
module cch_back
   import cch_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_COLORS  = 256,
   parameter int HW          = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire logic          q_func,
   input  wire logic [31:0]   q_color,
   input  wire logic [HW-1:0] q_home,
   output logic               q_pop,
   output logic               clearing,
   input  wire logic [1:0]    code_width,
   input  wire logic [31:0]   transparent_key,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_found,
   output logic               rsp_table_full,
   output logic [7:0]         rsp_code_number,
   output logic [6:0]         rsp_symbol_0,
   output logic [6:0]         rsp_symbol_1,
   output logic [6:0]         rsp_symbol_2,
   output logic               rsp_is_transparent
);

   localparam int CW   = $clog2(MAX_COLORS);
   localparam int CNTW = $clog2(MAX_COLORS + 1);
   // word: used | link | next | code | color
   localparam int WW   = 34 + CW + HW;
   localparam int P_CODE = 32;
   localparam int P_NEXT = 32 + CW;
   localparam int P_LINK = 32 + CW + HW;
   localparam int P_USED = 33 + CW + HW;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_PROBE = 4'd3;
   localparam logic [3:0] S_WNEW  = 4'd4;
   localparam logic [3:0] S_DIG1  = 4'd5;
   localparam logic [3:0] S_DIG2  = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   logic [WW-1:0]   mem [TABLE_DEPTH];
   logic [WW-1:0]   rdata_ff;
   logic [HW-1:0]   rd_addr, wr_addr;
   logic [WW-1:0]   wr_data;
   logic            wr_en;

   logic [3:0]      state_ff, state_in;
   logic [HW-1:0]   clr_ff, clr_in;
   logic [HW-1:0]   cur_ff, cur_in, cur_inc;
   logic [HW-1:0]   tail_ff, tail_in;
   logic [WW-1:0]   tail_word_ff, tail_word_in, link_word;
   logic            func_ff, func_in;
   logic [31:0]     color_ff, color_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CW-1:0]   code_ff, code_in;
   logic            found_ff, found_in;
   logic            full_ff, full_in;
   div91_type       div0_ff, div0_in, div1_ff, div1_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_found_ff, rsp_full_ff, rsp_trans_ff;
   logic [7:0]      rsp_code_ff;
   logic [6:0]      rsp_sym0_ff, rsp_sym1_ff, rsp_sym2_ff;
   logic            rsp_load;

   logic            r_used, r_link;
   logic [HW-1:0]   r_next;
   logic [CW-1:0]   r_code;
   logic [31:0]     r_color;
   logic            at_limit;
   logic [WW-1:0]   new_word;
   logic [1:0]      eff_width;

   assign r_used  = rdata_ff[P_USED];
   assign r_link  = rdata_ff[P_LINK];
   assign r_next  = rdata_ff[P_NEXT +: HW];
   assign r_code  = rdata_ff[P_CODE +: CW];
   assign r_color = rdata_ff[31:0];

   assign at_limit = (32'(count_ff) >= 32'(MAX_COLORS)) ||
                     (32'(count_ff) >= 32'(TABLE_DEPTH));
   assign cur_inc  = (cur_ff == HW'(TABLE_DEPTH - 1)) ? '0 : cur_ff + 1'b1;
   assign new_word = {1'b1, 1'b0, {HW{1'b0}}, CW'(count_ff), color_ff};

   always_comb begin
      link_word                 = tail_word_ff;
      link_word[P_LINK]         = 1'b1;
      link_word[P_NEXT +: HW]   = cur_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_load = (~rsp_valid_ff | ~rsp_stall) & (state_ff == S_OUT);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      tail_in      = tail_ff;
      tail_word_in = tail_word_ff;
      func_in      = func_ff;
      color_in     = color_ff;
      count_in     = count_ff;
      code_in      = code_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      div0_in      = div0_ff;
      div1_in      = div1_ff;
      rd_addr      = cur_ff;
      wr_addr      = cur_ff;
      wr_data      = new_word;
      wr_en        = 1'b0;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == HW'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               func_in  = q_func;
               color_in = q_color;
               cur_in   = q_home;
               rd_addr  = q_home;
               found_in = 1'b0;
               full_in  = 1'b0;
               code_in  = '0;
               if (q_func == FUNC_INSERT && at_limit) begin
                  full_in  = 1'b1;
                  state_in = S_DIG1;
               end else begin
                  state_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            if (func_ff == FUNC_LOOKUP) begin
               if (r_used && r_color == color_ff) begin
                  found_in = 1'b1;
                  code_in  = r_code;
                  state_in = S_DIG1;
               end else if (r_used && r_link) begin
                  cur_in  = r_next;
                  rd_addr = r_next;
               end else begin
                  state_in = S_DIG1;
               end
            end else begin
               if (!r_used) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  code_in  = CW'(count_ff);
                  found_in = 1'b1;
                  state_in = S_DIG1;
               end else if (r_link) begin
                  cur_in  = r_next;
                  rd_addr = r_next;
               end else begin
                  tail_in      = cur_ff;
                  tail_word_in = rdata_ff;
                  cur_in       = cur_inc;
                  rd_addr      = cur_inc;
                  state_in     = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!r_used) begin
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               wr_data  = link_word;
               state_in = S_WNEW;
            end else begin
               cur_in  = cur_inc;
               rd_addr = cur_inc;
            end
         end
         S_WNEW: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            code_in  = CW'(count_ff);
            found_in = 1'b1;
            state_in = S_DIG1;
         end
         S_DIG1: begin
            div0_in  = div91(16'(code_ff));
            state_in = S_DIG2;
         end
         S_DIG2: begin
            div1_in  = div91(16'(div0_ff.quot));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
      cur_ff       <= cur_in;
      tail_ff      <= tail_in;
      tail_word_ff <= tail_word_in;
      func_ff      <= func_in;
      color_ff     <= color_in;
      code_ff      <= code_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
      div0_ff      <= div0_in;
      div1_ff      <= div1_in;
   end

   assign eff_width    = (code_width == 2'd0) ? 2'd1 : code_width;
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_full_ff  <= full_ff;
         rsp_code_ff  <= found_ff ? 8'(code_ff) : 8'd0;
         rsp_sym0_ff  <= found_ff ? sym_char(div0_ff.rem) : 7'd0;
         rsp_sym1_ff  <= (found_ff && eff_width >= 2'd2) ? sym_char(div1_ff.rem) : 7'd0;
         rsp_sym2_ff  <= (found_ff && eff_width == 2'd3) ?
                         sym_char(div1_ff.quot[6:0]) : 7'd0;
         rsp_trans_ff <= found_ff && (color_ff == transparent_key);
      end
   end

   assign clearing           = (state_ff == S_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_code_number    = rsp_code_ff;
   assign rsp_symbol_0       = rsp_sym0_ff;
   assign rsp_symbol_1       = rsp_sym1_ff;
   assign rsp_symbol_2       = rsp_sym2_ff;
   assign rsp_is_transparent = rsp_trans_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/color_code_hash_table.sv =====
// Flow: an accepted input is hashed into a register stage and written to a 2-entry queue;
//   the table walker pops it, reads its home slot and follows chain links. An insert
//   whose slot is taken probes onward, links a free slot after the tail and writes the
//   new entry. A refused insert skips the table; symbols are then formed and registered.
// Occupancy: one item in the table walker; the hash stage and queue run three items ahead.
// Reset: synchronous; after reset the table is cleared one slot a cycle, with req_stall
//   high until every slot is clear. Config writes are taken throughout.
`default_nettype none
module color_code_hash_table
   import cch_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_COLORS  = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [31:0] req_color_rgba,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic             rsp_table_full,
   output logic [7:0]       rsp_code_number,
   output logic [6:0]       rsp_symbol_0,
   output logic [6:0]       rsp_symbol_1,
   output logic [6:0]       rsp_symbol_2,
   output logic             rsp_is_transparent,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int HW = $clog2(TABLE_DEPTH);

   logic [1:0]    code_width_ff;
   logic [31:0]   transparent_key_ff;
   logic          q_valid, q_func, q_pop, clearing;
   logic [31:0]   q_color;
   logic [HW-1:0] q_home;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_width_ff      <= 2'd1;
         transparent_key_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CODE_WIDTH:      code_width_ff      <= csr_wdata[1:0];
            CSR_TRANSPARENT_KEY: transparent_key_ff <= csr_wdata;
            default:             code_width_ff      <= code_width_ff;
         endcase
      end
   end

   cch_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .HW          (HW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_color_rgba (req_color_rgba),
      .hold           (clearing),
      .q_valid        (q_valid),
      .q_func         (q_func),
      .q_color        (q_color),
      .q_home         (q_home),
      .q_pop          (q_pop)
   );

   cch_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_COLORS  (MAX_COLORS),
      .HW          (HW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_func             (q_func),
      .q_color            (q_color),
      .q_home             (q_home),
      .q_pop              (q_pop),
      .clearing           (clearing),
      .code_width         (code_width_ff),
      .transparent_key    (transparent_key_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_table_full     (rsp_table_full),
      .rsp_code_number    (rsp_code_number),
      .rsp_symbol_0       (rsp_symbol_0),
      .rsp_symbol_1       (rsp_symbol_1),
      .rsp_symbol_2       (rsp_symbol_2),
      .rsp_is_transparent (rsp_is_transparent)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/cch_checker.sv =====
`default_nettype none
module cch_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_found,
   input wire logic       rsp_table_full,
   input wire logic [7:0] rsp_code_number,
   input wire logic [6:0] rsp_symbol_0,
   input wire logic [6:0] rsp_symbol_1,
   input wire logic [6:0] rsp_symbol_2,
   input wire logic       rsp_is_transparent
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_number) &&
      $stable(rsp_found) && $stable(rsp_symbol_0))
      else $error("result changed while stalled");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_table_full))
      else $error("found and table_full both set");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_code_number == 8'd0 && rsp_symbol_0 == 7'd0 &&
      rsp_symbol_1 == 7'd0 && rsp_symbol_2 == 7'd0 && !rsp_is_transparent)
      else $error("miss or full item carries nonzero fields");

   a_hit_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_symbol_0 != 7'd0)
      else $error("hit item without first symbol");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind color_code_hash_table cch_checker u_cch_checker (.*);
`default_nettype wire
